>>> rtl/core/ihdp_pkg.sv
// Shared types, constants and helper functions for the image header dimension probe.
`default_nettype none

package ihdp_pkg;

   localparam int ByteWidth  = 8;
   localparam int SideWidth  = 16;
   localparam int DimWidth   = 32;
   localparam int FmtWidth   = 2;
   localparam int PosWidth   = 5;
   localparam int SkipWidth  = 17;
   localparam int PhaseWidth = 4;
   localparam int RspWidth   = 72;

   localparam logic [FmtWidth-1:0] FMT_NONE = 2'd0;
   localparam logic [FmtWidth-1:0] FMT_PNG  = 2'd1;
   localparam logic [FmtWidth-1:0] FMT_JPEG = 2'd2;

   localparam logic [SideWidth-1:0] MAX_SIDE_RESET = 16'd4096;

   localparam logic [ByteWidth-1:0] PNG_FIRST   = 8'h89;
   localparam logic [ByteWidth-1:0] JPG_PREFIX  = 8'hFF;
   localparam logic [ByteWidth-1:0] JPG_SOI     = 8'hD8;
   localparam logic [ByteWidth-1:0] JPG_EOI     = 8'hD9;
   localparam logic [ByteWidth-1:0] JPG_SOS     = 8'hDA;
   localparam logic [ByteWidth-1:0] JPG_RST_LO  = 8'hD0;
   localparam logic [ByteWidth-1:0] JPG_RST_HI  = 8'hD7;
   localparam logic [ByteWidth-1:0] JPG_SOF_LO  = 8'hC0;
   localparam logic [ByteWidth-1:0] JPG_SOF_HI  = 8'hCF;
   localparam logic [ByteWidth-1:0] JPG_DHT     = 8'hC4;
   localparam logic [ByteWidth-1:0] JPG_JPG     = 8'hC8;
   localparam logic [ByteWidth-1:0] JPG_DAC     = 8'hCC;
   localparam logic [ByteWidth-1:0] JPG_TEM     = 8'h01;
   localparam logic [ByteWidth-1:0] JPG_STUFF   = 8'h00;

   typedef struct packed {
      logic                 valid;
      logic [FmtWidth-1:0]  format;
      logic [DimWidth-1:0]  width;
      logic [DimWidth-1:0]  height;
      logic                 within_limits;
   } result_type;

   function automatic logic [ByteWidth-1:0] png_sig_byte(input logic [2:0] idx);
      logic [ByteWidth-1:0] sig;
      case (idx)
         3'd0: sig = 8'h89;
         3'd1: sig = 8'h50;
         3'd2: sig = 8'h4E;
         3'd3: sig = 8'h47;
         3'd4: sig = 8'h0D;
         3'd5: sig = 8'h0A;
         3'd6: sig = 8'h1A;
         3'd7: sig = 8'h0A;
         default: sig = 8'h00;
      endcase
      return sig;
   endfunction

   function automatic logic is_sof(input logic [ByteWidth-1:0] m);
      return (m >= JPG_SOF_LO) && (m <= JPG_SOF_HI) && (m != JPG_DHT) &&
             (m != JPG_JPG) && (m != JPG_DAC);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ihdp_scan.sv
// Byte scanner: format detection state machine and dimension capture.
`default_nettype none

module ihdp_scan
   import ihdp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [ByteWidth-1:0] data_byte,
   input  wire logic                 last_byte,
   input  wire logic [SideWidth-1:0] max_side,
   output result_type                result
);

   localparam logic [PhaseWidth-1:0] PH_START  = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_PNGSIG = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_SOI    = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_SEEK   = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_MARK   = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_LENHI  = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_LENLO  = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_SKIP   = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_SOF    = 4'd8;
   localparam logic [PhaseWidth-1:0] PH_DONE   = 4'd9;

   logic [PhaseWidth-1:0] phase_ff,  phase_in;
   logic [PosWidth-1:0]   pos_ff,    pos_in;
   logic [SkipWidth-1:0]  skip_ff,   skip_in;
   logic [ByteWidth-1:0]  marker_ff, marker_in;
   logic [DimWidth-1:0]   width_ff,  width_in;
   logic [DimWidth-1:0]   height_ff, height_in;
   logic [FmtWidth-1:0]   fmt_ff,    fmt_in;

   logic [SkipWidth-1:0]  len_full;
   logic [SkipWidth-1:0]  skip_dec;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      skip_in   = skip_ff;
      marker_in = marker_ff;
      width_in  = width_ff;
      height_in = height_ff;
      fmt_in    = fmt_ff;
      len_full  = {skip_ff[SkipWidth-1:ByteWidth], data_byte};
      skip_dec  = skip_ff - SkipWidth'(1);

      case (phase_ff)
         PH_START: begin
            if (data_byte == PNG_FIRST) begin
               phase_in = PH_PNGSIG;
               pos_in   = PosWidth'(1);
            end else if (data_byte == JPG_PREFIX) begin
               phase_in = PH_SOI;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_PNGSIG: begin
            pos_in = pos_ff + PosWidth'(1);
            if (pos_ff < PosWidth'(8)) begin
               if (data_byte != png_sig_byte(pos_ff[2:0])) begin
                  phase_in = PH_DONE;
                  pos_in   = pos_ff;
               end
            end else if (pos_ff >= PosWidth'(16) && pos_ff < PosWidth'(20)) begin
               width_in = {width_ff[DimWidth-ByteWidth-1:0], data_byte};
            end else if (pos_ff >= PosWidth'(20)) begin
               height_in = {height_ff[DimWidth-ByteWidth-1:0], data_byte};
               if (pos_ff == PosWidth'(23)) begin
                  fmt_in   = FMT_PNG;
                  phase_in = PH_DONE;
                  pos_in   = pos_ff;
               end
            end
         end
         PH_SOI: begin
            phase_in = (data_byte == JPG_SOI) ? PH_SEEK : PH_DONE;
         end
         PH_SEEK: begin
            if (data_byte == JPG_PREFIX) begin
               phase_in = PH_MARK;
            end
         end
         PH_MARK: begin
            marker_in = data_byte;
            if (data_byte == JPG_STUFF || data_byte == JPG_TEM || data_byte == JPG_PREFIX ||
                (data_byte >= JPG_RST_LO && data_byte <= JPG_RST_HI)) begin
               phase_in = PH_SEEK;
            end else if (data_byte == JPG_EOI || data_byte == JPG_SOS) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_LENHI;
            end
         end
         PH_LENHI: begin
            skip_in  = {1'b0, data_byte, {ByteWidth{1'b0}}};
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            skip_in = len_full;
            if (len_full < SkipWidth'(2)) begin
               phase_in = PH_DONE;
            end else if (is_sof(marker_ff)) begin
               pos_in   = '0;
               phase_in = PH_SOF;
            end else begin
               skip_in  = len_full - SkipWidth'(2);
               phase_in = (len_full == SkipWidth'(2)) ? PH_SEEK : PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_SEEK;
            end
         end
         PH_SOF: begin
            if (pos_ff == PosWidth'(1) || pos_ff == PosWidth'(2)) begin
               height_in = {{(DimWidth-2*ByteWidth){1'b0}}, height_ff[ByteWidth-1:0], data_byte};
            end else if (pos_ff == PosWidth'(3) || pos_ff == PosWidth'(4)) begin
               width_in = {{(DimWidth-2*ByteWidth){1'b0}}, width_ff[ByteWidth-1:0], data_byte};
            end
            if (pos_ff >= PosWidth'(4)) begin
               fmt_in   = FMT_JPEG;
               phase_in = PH_DONE;
            end else begin
               pos_in = pos_ff + PosWidth'(1);
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   logic [DimWidth-1:0] max_wide;

   always_comb begin
      max_wide             = {{(DimWidth-SideWidth){1'b0}}, max_side};
      result.valid         = step && last_byte;
      result.format        = fmt_in;
      if (fmt_in == FMT_NONE) begin
         result.width         = '0;
         result.height        = '0;
         result.within_limits = 1'b0;
      end else begin
         result.width         = width_in;
         result.height        = height_in;
         result.within_limits = (width_in != '0) && (height_in != '0) &&
                                (width_in <= max_wide) && (height_in <= max_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff  <= PH_START;
         pos_ff    <= '0;
         skip_ff   <= '0;
         marker_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         fmt_ff    <= FMT_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         skip_ff   <= skip_in;
         marker_ff <= marker_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         fmt_ff    <= fmt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ihdp_rsp_buf.sv
// Two-entry response buffer: output register with a skid entry behind it.
`default_nettype none

module ihdp_rsp_buf
   import ihdp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  result_type push_item,
   output logic       can_accept,
   output logic       out_valid,
   input  wire logic  out_ready,
   output result_type out_item
);

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       head_free;

   always_comb begin
      head_free     = !head_valid_ff || out_ready;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (head_free) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_valid_in = push_item.valid;
            skid_in       = push_item;
         end else begin
            head_in       = push_item;
            head_valid_in = push_item.valid;
         end
      end else if (push_item.valid) begin
         skid_in       = push_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign can_accept = !skid_valid_ff;
   assign out_valid  = head_valid_ff;
   assign out_item   = head_ff;

endmodule

`default_nettype wire

>>> rtl/core/image_header_dimension_probe_core.sv
// Top level of the image header dimension probe: register, scanner and response buffer.
//
//  Channel  Direction  Payload
//  req_     in         data_byte, last_byte (tlast)
//  rsp_     out        format, width, height, within_limits
//  csr_     in         max_side
//
// One byte request is taken every cycle while the skid entry is free; the result of a buffer
// is written into the response buffer when its last byte is taken.
// The scanner phase machine settles each byte combinationally and registers its state when the byte is taken.
// A two-entry response buffer lets bytes keep flowing while a result waits;
// requests stall only when both entries hold unread results.
// Synchronous reset clears the scan state and sets max_side to 4096.
`default_nettype none

module image_header_dimension_probe_core
   import ihdp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteWidth-1:0] req_tdata,   // data_byte[7:0]
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RspWidth-1:0]       rsp_tdata,   // format[1:0], width[33:2], height[65:34],
                                                  // within_limits[66], zero[71:67]
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [SideWidth-1:0] csr_data
);

   logic [SideWidth-1:0] max_side_ff;
   logic                 step;
   result_type           scan_result;
   result_type           rsp_item;

   assign csr_ready = 1'b1;
   assign step      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_side_ff <= MAX_SIDE_RESET;
      end else if (csr_valid) begin
         max_side_ff <= csr_data;
      end
   end

   ihdp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .max_side  (max_side_ff),
      .result    (scan_result)
   );

   ihdp_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_item  (scan_result),
      .can_accept (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (rsp_item)
   );

   assign rsp_tdata = {5'b0, rsp_item.within_limits, rsp_item.height, rsp_item.width,
                       rsp_item.format};

endmodule

`default_nettype wire
